>>> hdl/wsp_pkg.sv
// wsp_pkg: shared constants, command and status types of the wheel speed PID block.
// Used by wsp_ctrl, wsp_dp and wheel_speed_pid. No dependencies.
package wsp_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 16;
   localparam int US_PER_SECOND_DEF  = 1000000;

   localparam int GAIN_W     = 24;
   localparam int MAXO_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 80;

   localparam int ACC_W      = 90;
   localparam int DIV_STEPS  = ACC_W / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int TERM_W     = 61;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_OUT = 2'd3;

   localparam logic [MAXO_W-1:0] MAX_OUT_RESET = 16'd8191;

   localparam logic [2:0] MS_ERR_EL = 3'd0;
   localparam logic [2:0] MS_GP_ERR = 3'd1;
   localparam logic [2:0] MS_GI_ILO = 3'd2;
   localparam logic [2:0] MS_GI_IHI = 3'd3;
   localparam logic [2:0] MS_GD_DE  = 3'd4;
   localparam logic [2:0] MS_TLO_US = 3'd5;
   localparam logic [2:0] MS_THI_US = 3'd6;

   typedef struct packed {
      logic       load;
      logic [2:0] mul_sel;
      logic       acc_set;
      logic       acc_add_hi;
      logic       int_upd;
      logic       t_wr;
      logic       div_load;
      logic       div_us;
      logic       div_step;
      logic       term_p_wr;
      logic       term_i_wr;
      logic       term_d_wr;
      logic       out_ld;
   } wsp_cmd_type;

   typedef struct packed {
      logic elapsed_zero;
      logic rsp_free;
   } wsp_sts_type;

endpackage

>>> hdl/wheel_speed_pid.sv
// wheel_speed_pid: top level of the variable time step wheel speed PID controller.
// Depends on wsp_pkg, wsp_ctrl and wsp_dp.
//
//  channel  dir  handshake                 payload
//  req      in   req_tvalid / req_tready   req_tdata, req_tuser (kind)
//  rsp      out  rsp_tvalid / rsp_tready   rsp_tdata
//  csr      in   csr_we                    csr_index, csr_wdata
//
// A control beat takes seven multiply steps on one shared 33x32 multiplier
// and two divisions (two quotient bits a cycle), one for the integral term
// and one for the derivative term. With zero elapsed time the second division
// is skipped; a clear beat goes straight to its result. Reset is synchronous;
// it restores the gains, output limit, PID state, result valid and sequencer state.
// A result waiting on rsp does not block acceptance; a step only waits at its end.
module wheel_speed_pid
   import wsp_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int US_PER_SECOND  = US_PER_SECOND_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // reverse, count_now, count_before, target_pulses, elapsed_us
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drive_level, measured_pulses, error_now, clamped
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   wsp_cmd_type cmd;
   wsp_sts_type sts;

   wsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   wsp_dp #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .US_PER_SECOND  (US_PER_SECOND)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/wsp_dp.sv
// wsp_dp: datapath of the wheel speed PID block: registers, shared multiplier,
// accumulator, two-bit-a-cycle divider, integrator state and result register.
// Depends on wsp_pkg.
module wsp_dp
   import wsp_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int US_PER_SECOND  = US_PER_SECOND_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wsp_cmd_type           cmd,
   output wsp_sts_type           sts,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [TERM_W-1:0] TERM_LIMIT = TERM_W'(1) << 60;
   localparam logic [31:0] US_VAL = 32'(US_PER_SECOND);

   logic signed [GAIN_W-1:0] gp_ff, gi_ff, gd_ff;
   logic [MAXO_W-1:0] maxo_ff;

   logic kind_ff, ez_ff;
   logic [30:0] meas_ff;
   logic signed [31:0] err_ff;
   logic [31:0] el_ff;
   logic signed [63:0] integ_ff;
   logic signed [32:0] last_ff;
   logic signed [33:0] de_ff;
   logic [56:0] t_ff;
   logic [64:0] m_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] dv_ff, dv_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff;
   logic signed [TERM_W:0] tp_ff, ti_ff, td_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [31:0] now_s, bef_s;
   logic signed [33:0] now_abs, bef_abs, diff;
   logic [33:0] dmag;
   logic [30:0] meas_c;
   logic signed [32:0] err_c;
   logic [31:0] emag, gpm, gim, gdm;
   logic [63:0] imag;
   logic [32:0] demag, mul_a;
   logic [31:0] mul_b;
   logic signed [64:0] sp, isum;
   logic signed [63:0] sum;
   logic [15:0] drive;
   logic clamped;

   function automatic logic signed [TERM_W:0] sat_term(input logic neg,
                                                       input logic [ACC_W-1:0] q);
      logic [TERM_W-1:0] mg;
      mg = (q > ACC_W'(TERM_LIMIT)) ? TERM_LIMIT : q[TERM_W-1:0];
      return neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
   endfunction

   assign now_s   = req_tdata[32:1];
   assign bef_s   = req_tdata[64:33];
   assign now_abs = now_s[31] ? -34'(now_s) : 34'(now_s);
   assign bef_abs = bef_s[31] ? -34'(bef_s) : 34'(bef_s);
   assign diff    = now_abs - bef_abs;
   assign dmag    = diff[33] ? 34'(-diff) : 34'(diff);
   assign meas_c  = (dmag > 34'h07FFFFFFF) ? 31'h7FFFFFFF : dmag[30:0];
   assign err_c   = $signed({17'd0, req_tdata[80:65]}) - $signed({2'b00, meas_c});

   assign emag  = err_ff[31] ? -32'(err_ff) : 32'(err_ff);
   assign gpm   = gp_ff[GAIN_W-1] ? -32'(gp_ff) : 32'(gp_ff);
   assign gim   = gi_ff[GAIN_W-1] ? -32'(gi_ff) : 32'(gi_ff);
   assign gdm   = gd_ff[GAIN_W-1] ? -32'(gd_ff) : 32'(gd_ff);
   assign imag  = integ_ff[63] ? 64'(-integ_ff) : 64'(integ_ff);
   assign demag = de_ff[33] ? 33'(-de_ff) : de_ff[32:0];

   always_comb begin
      case (cmd.mul_sel)
         MS_ERR_EL: begin mul_a = {1'b0, emag};       mul_b = el_ff; end
         MS_GP_ERR: begin mul_a = {1'b0, emag};       mul_b = gpm;   end
         MS_GI_ILO: begin mul_a = {1'b0, imag[31:0]}; mul_b = gim;   end
         MS_GI_IHI: begin mul_a = {1'b0, imag[63:32]}; mul_b = gim;  end
         MS_GD_DE:  begin mul_a = demag;              mul_b = gdm;   end
         MS_TLO_US: begin mul_a = {1'b0, t_ff[31:0]}; mul_b = US_VAL; end
         MS_THI_US: begin mul_a = 33'(t_ff[56:32]);   mul_b = US_VAL; end
         default:   begin mul_a = '0;                 mul_b = '0;    end
      endcase
   end

   assign sp   = err_ff[31] ? -$signed({1'b0, m_ff[63:0]}) : $signed({1'b0, m_ff[63:0]});
   assign isum = $signed({integ_ff[63], integ_ff}) + sp;

   always_comb begin
      logic [33:0] trial;
      dv_in  = dv_ff;
      rem_in = rem_ff;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_in, dv_in[ACC_W-1]} - {2'b00, dsr_ff};
         if (!trial[33]) begin
            rem_in = trial[32:0];
            dv_in  = {dv_in[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_in[31:0], dv_in[ACC_W-1]};
            dv_in  = {dv_in[ACC_W-2:0], 1'b0};
         end
      end
   end

   assign sum = 64'(tp_ff) + 64'(ti_ff) + 64'(td_ff);
   always_comb begin
      if (sum < 0) begin
         drive = '0; clamped = 1'b1;
      end else if (sum > $signed({48'd0, maxo_ff})) begin
         drive = maxo_ff; clamped = 1'b1;
      end else begin
         drive = sum[15:0]; clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= '0; gi_ff <= '0; gd_ff <= '0; maxo_ff <= MAX_OUT_RESET;
         integ_ff <= '0; last_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GAIN_P:  gp_ff   <= csr_wdata;
               REG_GAIN_I:  gi_ff   <= csr_wdata;
               REG_GAIN_D:  gd_ff   <= csr_wdata;
               REG_MAX_OUT: maxo_ff <= csr_wdata[MAXO_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load && req_tuser) begin
            integ_ff <= '0;
            last_ff  <= '0;
         end else if (cmd.int_upd) begin
            last_ff <= 33'(err_ff);
            if (!ez_ff) begin
               if (isum[64] != isum[63])
                  integ_ff <= isum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               else
                  integ_ff <= isum[63:0];
            end
         end
         if (cmd.out_ld)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= 65'(mul_a) * 65'(mul_b);
      if (cmd.load) begin
         kind_ff <= req_tuser;
         meas_ff <= meas_c;
         err_ff  <= err_c[31:0];
         el_ff   <= req_tdata[112:81];
         ez_ff   <= (req_tdata[112:81] == 32'd0);
         td_ff   <= '0;
      end
      if (cmd.int_upd)
         de_ff <= 34'(err_ff) - 34'(last_ff);
      if (cmd.acc_set)
         acc_ff <= ACC_W'(m_ff);
      else if (cmd.acc_add_hi)
         acc_ff <= acc_ff + (ACC_W'(m_ff) << 32);
      if (cmd.t_wr)
         t_ff <= m_ff[56:0];
      if (cmd.div_load) begin
         dv_ff  <= acc_ff >> GAIN_FRAC_BITS;
         rem_ff <= '0;
         dsr_ff <= cmd.div_us ? US_VAL : el_ff;
      end else if (cmd.div_step) begin
         dv_ff  <= dv_in;
         rem_ff <= rem_in;
      end
      if (cmd.term_p_wr)
         tp_ff <= sat_term(gp_ff[GAIN_W-1] ^ err_ff[31], acc_ff >> GAIN_FRAC_BITS);
      if (cmd.term_i_wr)
         ti_ff <= sat_term(gi_ff[GAIN_W-1] ^ integ_ff[63], dv_ff);
      if (cmd.term_d_wr)
         td_ff <= sat_term(gd_ff[GAIN_W-1] ^ de_ff[33], dv_ff);
      if (cmd.out_ld)
         rsp_data_ff <= kind_ff ? '0 : {clamped, err_ff, meas_ff, drive};
   end

   assign sts.elapsed_zero = ez_ff;
   assign sts.rsp_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

endmodule

>>> hdl/wsp_ctrl.sv
// wsp_ctrl: sequencer of the wheel speed PID block; issues datapath commands.
// Depends on wsp_pkg.
module wsp_ctrl
   import wsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,
   input  wsp_sts_type sts,
   output wsp_cmd_type cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MINT = 5'd1;
   localparam logic [4:0] S_UINT = 5'd2;
   localparam logic [4:0] S_AP   = 5'd3;
   localparam logic [4:0] S_AI0  = 5'd4;
   localparam logic [4:0] S_AI1  = 5'd5;
   localparam logic [4:0] S_AD0  = 5'd6;
   localparam logic [4:0] S_DIVI = 5'd7;
   localparam logic [4:0] S_TI   = 5'd8;
   localparam logic [4:0] S_MD0  = 5'd9;
   localparam logic [4:0] S_MD1  = 5'd10;
   localparam logic [4:0] S_DLD  = 5'd11;
   localparam logic [4:0] S_DIVD = 5'd12;
   localparam logic [4:0] S_TD   = 5'd13;
   localparam logic [4:0] S_FIN  = 5'd14;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   logic [4:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MS_ERR_EL;
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = req_tuser ? S_FIN : S_MINT;
         end
         S_MINT: begin
            cmd.mul_sel = MS_ERR_EL; state_in = S_UINT;
         end
         S_UINT: begin
            cmd.int_upd = 1'b1; cmd.mul_sel = MS_GP_ERR; state_in = S_AP;
         end
         S_AP: begin
            cmd.acc_set = 1'b1; cmd.mul_sel = MS_GI_ILO; state_in = S_AI0;
         end
         S_AI0: begin
            cmd.term_p_wr = 1'b1; cmd.acc_set = 1'b1; cmd.mul_sel = MS_GI_IHI;
            state_in = S_AI1;
         end
         S_AI1: begin
            cmd.acc_add_hi = 1'b1; cmd.mul_sel = MS_GD_DE; state_in = S_AD0;
         end
         S_AD0: begin
            cmd.t_wr = 1'b1; cmd.div_load = 1'b1; cmd.div_us = 1'b1;
            cnt_in = '0; state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_step = 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_TI;
         end
         S_TI: begin
            cmd.term_i_wr = 1'b1; cmd.mul_sel = MS_TLO_US;
            state_in = sts.elapsed_zero ? S_FIN : S_MD0;
         end
         S_MD0: begin
            cmd.acc_set = 1'b1; cmd.mul_sel = MS_THI_US; state_in = S_MD1;
         end
         S_MD1: begin
            cmd.acc_add_hi = 1'b1; state_in = S_DLD;
         end
         S_DLD: begin
            cmd.div_load = 1'b1; cnt_in = '0; state_in = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_TD;
         end
         S_TD: begin
            cmd.term_d_wr = 1'b1; state_in = S_FIN;
         end
         S_FIN: begin
            cmd.out_ld = sts.rsp_free;
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start a step");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVI || state_ff == S_DIVD) |-> (cnt_ff <= DIV_LAST))
      else $error("divider count out of range");
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |=> (state_ff == S_IDLE))
      else $error("result load did not end the step");

endmodule

>>> tb/wheel_speed_pid_tb.sv
// wheel_speed_pid_tb: self-checking testbench for the wheel speed PID controller.
// Drives step and clear beats, predicts each result in-line and checks rsp beats.
// Depends on wsp_pkg and wheel_speed_pid.
`timescale 1ns / 100ps

module wheel_speed_pid_tb
   import wsp_pkg::*;
();

   typedef struct {
      bit              kind;
      bit              reverse;
      bit signed [31:0] count_now;
      bit signed [31:0] count_before;
      bit [15:0]       target;
      bit [31:0]       elapsed;
   } step_type;

   typedef struct {
      bit [15:0] drive;
      bit [30:0] measured;
      bit [31:0] err;
      bit        clamped;
   } drive_result_type;

   localparam longint TERM_CAP = 64'sd1 <<< 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // controller model state
   longint    gain_p, gain_i, gain_d;
   bit [15:0] max_out;
   longint    integ, err_last;

   drive_result_type expected_drive[$];
   int  error_count = 0;
   bit  quiet = 1'b0;
   int  rsp_hold = 0;

   wheel_speed_pid u_dut (.*);

   always #1 clock = ~clock;

   function automatic bit [127:0] mag128(longint v);
      logic signed [127:0] w;
      w = v;
      return w < 0 ? -w : w;
   endfunction

   function automatic longint scaled_term(bit neg, bit [127:0] x, bit [127:0] d);
      bit [127:0] q;
      q = (x >> 16) / d;
      if (q > 128'(TERM_CAP)) q = 128'(TERM_CAP);
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic drive_result_type predict_drive(step_type s);
      drive_result_type r;
      longint now_v, before_v, diff, measured, err, kp, ki, kd, de, sum;
      logic signed [127:0] acc;
      r = '{default: 0};
      if (s.kind) begin
         integ = 0;
         err_last = 0;
         return r;
      end
      now_v = s.count_now;
      before_v = s.count_before;
      diff = (now_v < 0 ? -now_v : now_v) - (before_v < 0 ? -before_v : before_v);
      measured = diff < 0 ? -diff : diff;
      if (measured > 64'h7FFF_FFFF) measured = 64'h7FFF_FFFF;
      err = longint'(s.target) - measured;
      if (s.elapsed != 0) begin
         acc = integ;
         acc = acc + err * longint'(s.elapsed);
         if (acc > 128'sh7FFF_FFFF_FFFF_FFFF) integ = 64'sh7FFF_FFFF_FFFF_FFFF;
         else if (acc < -128'sh8000_0000_0000_0000) integ = 64'sh8000_0000_0000_0000;
         else integ = longint'(acc);
      end
      kp = scaled_term((gain_p < 0) != (err < 0), mag128(gain_p) * mag128(err), 1);
      ki = scaled_term((gain_i < 0) != (integ < 0), mag128(gain_i) * mag128(integ),
                       US_PER_SECOND_DEF);
      kd = 0;
      if (s.elapsed != 0) begin
         de = err - err_last;
         kd = scaled_term((gain_d < 0) != (de < 0),
                          mag128(gain_d) * mag128(de) * US_PER_SECOND_DEF, s.elapsed);
      end
      err_last = err;
      sum = kp + ki + kd;
      if (sum < 0) begin
         r.drive = 0;
         r.clamped = 1;
      end else if (sum > longint'(max_out)) begin
         r.drive = max_out;
         r.clamped = 1;
      end else begin
         r.drive = sum[15:0];
      end
      r.measured = measured[30:0];
      r.err = err[31:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      drive_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drive.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[15:0], -1);
         end else begin
            w = expected_drive.pop_front();
            if (rsp_tdata[15:0] !== w.drive) report_mismatch("drive_level", rsp_tdata[15:0], w.drive);
            if (rsp_tdata[46:16] !== w.measured)
               report_mismatch("measured_pulses", rsp_tdata[46:16], w.measured);
            if (rsp_tdata[78:47] !== w.err)
               report_mismatch("error_now", $signed(rsp_tdata[78:47]), $signed(w.err));
            if (rsp_tdata[79] !== w.clamped) report_mismatch("clamped", rsp_tdata[79], w.clamped);
         end
      end
   end

   // receiver
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            rsp_hold--;
         end else if (quiet) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(99) >= 13);
         end
      end
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   // called at a falling edge; leaves tvalid high on return
   task automatic send_step(step_type s);
      if (!quiet && $urandom_range(99) < 13) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = s.kind;
      req_tdata = '0;
      req_tdata[0] = s.reverse;
      req_tdata[32:1] = s.count_now;
      req_tdata[64:33] = s.count_before;
      req_tdata[80:65] = s.target;
      req_tdata[112:81] = s.elapsed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_drive.push_back(predict_drive(s));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (expected_drive.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         REG_GAIN_P: gain_p = longint'($signed(val));
         REG_GAIN_I: gain_i = longint'($signed(val));
         REG_GAIN_D: gain_d = longint'($signed(val));
         default: max_out = val[15:0];
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_gains(int gp, int gi, int gd, int mo);
      drain();
      write_reg(REG_GAIN_P, gp[23:0]);
      write_reg(REG_GAIN_I, gi[23:0]);
      write_reg(REG_GAIN_D, gd[23:0]);
      write_reg(REG_MAX_OUT, mo[23:0]);
   endtask

   function automatic step_type mk_step(bit k, int cn, int cb, int tg, bit [31:0] el);
      step_type s;
      s.kind = k;
      s.reverse = $urandom_range(1);
      s.count_now = cn;
      s.count_before = cb;
      s.target = tg[15:0];
      s.elapsed = el;
      return s;
   endfunction

   function automatic step_type rand_step();
      step_type s;
      int sel;
      sel = $urandom_range(99);
      s = mk_step(($urandom_range(99) < 3), 0, 0, $urandom_range(16'hFFFF), 0);
      if (sel < 70) begin
         s.count_before = $urandom;
         s.count_before = s.count_before >>> $urandom_range(31);
         s.count_now = s.count_before + int'($urandom_range(4000)) - 2000;
         s.target = $urandom_range(3000);
      end else begin
         s.count_now = $urandom;
         s.count_before = $urandom;
      end
      sel = $urandom_range(99);
      if (sel < 8) s.elapsed = 0;
      else if (sel < 80) s.elapsed = $urandom_range(200, 50000);
      else if (sel < 92) s.elapsed = $urandom;
      else s.elapsed = $urandom_range(1, 20);
      return s;
   endfunction

   task automatic test_directed();
      set_gains(24'h01_0000, 24'h00_8000, 24'h00_0400, 16'd8191);
      send_step(mk_step(0, 100, 0, 150, 10000));
      send_step(mk_step(0, -250, 100, 200, 10000));
      send_step(mk_step(0, 32'sh8000_0000, 0, 16'hFFFF, 32'hFFFF_FFFF));
      send_step(mk_step(0, 0, 32'sh8000_0000, 0, 1));
      send_step(mk_step(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 5000));
      send_step(mk_step(0, 500, 400, 120, 0));
      send_step(mk_step(0, 500, 400, 80, 0));
      send_step(mk_step(1, 1234, -99, 77, 12345));
      send_step(mk_step(0, 10, 0, 16'hFFFF, 32'hFFFF_FFFF));
      send_step(mk_step(0, 10, 0, 16'hFFFF, 32'hFFFF_FFFF));
      send_step(mk_step(0, -1, -1, 0, 1));
      set_gains(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 16'hFFFF);
      send_step(mk_step(0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF));
      send_step(mk_step(0, 32'sh8000_0000, 1, 0, 1));
      send_step(mk_step(0, 3, 4, 5, 0));
      set_gains(-24'sh80_0000, -24'sh80_0000, -24'sh80_0000, 0);
      send_step(mk_step(0, 32'sh7FFF_FFFF, 0, 0, 32'hFFFF_FFFF));
      send_step(mk_step(0, 0, 32'sh7FFF_FFFF, 16'hFFFF, 1));
      send_step(mk_step(1, 0, 0, 0, 0));
      send_step(mk_step(0, 50, 0, 60, 1000));
   endtask

   task automatic test_random(int n);
      int gp, gi, gd, mo;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 2 == 0) begin
            gp = $urandom_range(24'h08_0000);
            gi = $urandom_range(24'h04_0000);
            gd = $urandom_range(24'h00_4000);
            mo = $urandom_range(16'hFFFF);
         end else begin
            gp = $urandom;
            gi = $urandom;
            gd = $urandom;
            mo = $urandom;
         end
         set_gains(gp, gi, gd, mo);
         quiet = (ph == 3);
         repeat (n) send_step(rand_step());
         quiet = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      set_gains(24'h02_0000, 24'h00_1000, 24'h00_0100, 16'd4000);
      quiet = 1'b1;
      rsp_hold = 600;
      repeat (20) send_step(rand_step());
      quiet = 1'b0;
   endtask

   task automatic test_pause();
      repeat (30) send_step(rand_step());
      req_tvalid = 1'b0;
      while (expected_drive.size() != 0) @(negedge clock);
      repeat (30) send_step(rand_step());
   endtask

   initial begin
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      max_out = MAX_OUT_RESET;
      integ = 0;
      err_last = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      send_step(mk_step(0, 40, 0, 30, 1000));
      test_directed();
      test_backpressure();
      test_pause();
      test_random(190);
      drain();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/wsp_pkg.sv
hdl/wsp_dp.sv
hdl/wsp_ctrl.sv
hdl/wheel_speed_pid.sv
tb/wheel_speed_pid_tb.sv
